FILE: design/pff_pkg.sv
// Package of shared types, constants and codes of the pipe friction factor core.
package pff_pkg;

    // Fraction bits of the friction factor result.
    localparam int RESULT_FRAC_BITS = 24;

    // Working value width (signed, Q.30) and magnitude width fed to the shared units.
    localparam int VW = 56;
    localparam int MW = 48;
    localparam int DW = 64;

    // Constants in Q.30, rounded to nearest.
    localparam logic [31:0] Q30_LN2  = 32'd744261118;
    localparam logic [31:0] Q30_C079 = 32'd848256041;
    localparam logic [31:0] Q30_C164 = 32'd1760936591;
    localparam logic [31:0] Q30_C086 = 32'd923417969;
    localparam logic [31:0] Q30_C251 = 32'd2695091978;
    localparam logic [31:0] SAT_VALUE = 32'hFFFF_FFFF;

    // 11/37 scaled by 2^30 and rounded up; the product with a 24-bit roughness,
    // shifted right by 30, gives floor(11 * eps / 37) exactly.
    localparam logic [31:0] EPS_DIV37 = 32'd319220543;

    // Status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_NOCONV = 2'd2;
    localparam logic [1:0] ST_SAT    = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LAMINAR = 2'd0;
    localparam logic [1:0] CFG_SMOOTH  = 2'd1;
    localparam logic [1:0] CFG_MAXIT   = 2'd2;
    localparam logic [1:0] CFG_TOL     = 2'd3;

    typedef logic signed [VW-1:0] t_val;

    // Request to and response from the shared divider.
    typedef struct packed {
        logic          start;
        logic [DW-1:0] dividend;
        logic [MW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quot;
    } t_div_rsp;

endpackage

FILE: design/pff_in_if.sv
// Input channel interface: Reynolds number and relative roughness.
interface pff_in_if;
    logic        valid;
    logic        ready;
    logic [39:0] reynolds;
    logic [23:0] rel_roughness;

    modport source (output valid, output reynolds, output rel_roughness, input ready);
    modport sink   (input valid, input reynolds, input rel_roughness, output ready);
endinterface

FILE: design/pff_out_if.sv
// Output channel interface: friction factor and status.
interface pff_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] friction_factor;
    logic [1:0]  status;

    modport source (output valid, output friction_factor, output status, input ready);
    modport sink   (input valid, input friction_factor, input status, output ready);
endinterface

FILE: design/pff_mul.sv
// Shared 32 by 32 bit unsigned multiplier with a registered product.
module pff_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    // One product per cycle, available in the next cycle.
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

FILE: design/pff_div.sv
// Shared restoring divider, one quotient bit per cycle.
module pff_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pff_pkg::t_div_req i_req,
    output pff_pkg::t_div_rsp o_rsp
);

    logic [pff_pkg::DW-1:0] r_q;
    logic [pff_pkg::MW-1:0] r_rem;
    logic [pff_pkg::MW-1:0] r_dvs;
    logic [5:0]             r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [pff_pkg::MW:0]   sh;
    logic                   ge;

    // Trial subtraction of the shifted partial remainder.
    assign sh = {r_rem, r_q[pff_pkg::DW-1]};
    assign ge = (sh >= {1'b0, r_dvs});

    // Control: busy flag, bit counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend register fills up with quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[pff_pkg::DW-2:0], ge};
            r_rem <= ge ? pff_pkg::MW'(sh - {1'b0, r_dvs}) : sh[pff_pkg::MW-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

FILE: design/pipe_friction_factor_core.sv
// Top level of the pipe friction factor core: sequencer over a shared multiplier and divider.
//
//  channel  | direction | payload                              | handshake
//  i_in     | in        | reynolds[39:0], rel_roughness[23:0]  | valid/ready
//  o_out    | out       | friction_factor[31:0], status[1:0]   | valid/ready
//  i_cfg_*  | in        | i_cfg_idx[1:0], i_cfg_data[31:0]     | write enable
//
// One transaction is worked at a time; i_in.ready is high only when the sequencer is idle.
// Laminar flow needs one division, the smooth formula a logarithm and two divisions, and the
// rough loop a division and a logarithm per iteration plus two divisions; run time is set by
// the divider and by the 30 squaring rounds of the logarithm on the shared multiplier.
// A result waits in the output register while o_out.ready is low.
// Reset is synchronous and active low; it restores the configuration register defaults.
module pipe_friction_factor_core #(
    parameter int RESULT_FRAC_BITS = pff_pkg::RESULT_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pff_in_if.sink      i_in,
    pff_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DISP  = 5'd1;
    localparam logic [4:0] S_DIVW  = 5'd2;
    localparam logic [4:0] S_MLO   = 5'd3;
    localparam logic [4:0] S_MHI   = 5'd4;
    localparam logic [4:0] S_MSUM  = 5'd5;
    localparam logic [4:0] S_LNORM = 5'd6;
    localparam logic [4:0] S_LSQ   = 5'd7;
    localparam logic [4:0] S_LSQW  = 5'd8;
    localparam logic [4:0] S_LAM   = 5'd9;
    localparam logic [4:0] S_SM1   = 5'd10;
    localparam logic [4:0] S_SM2   = 5'd11;
    localparam logic [4:0] S_E     = 5'd12;
    localparam logic [4:0] S_ITER  = 5'd13;
    localparam logic [4:0] S_IT1   = 5'd14;
    localparam logic [4:0] S_IT2   = 5'd15;
    localparam logic [4:0] S_IT3   = 5'd16;
    localparam logic [4:0] S_IT4   = 5'd17;
    localparam logic [4:0] S_INV0  = 5'd18;
    localparam logic [4:0] S_INV1  = 5'd19;
    localparam logic [4:0] S_INV2  = 5'd20;
    localparam logic [4:0] S_OUT   = 5'd21;

    localparam int VW = pff_pkg::VW;
    localparam int MW = pff_pkg::MW;
    localparam int DW = pff_pkg::DW;

    localparam logic [DW-1:0] LAM_NUM = DW'(1) << (RESULT_FRAC_BITS + 14);
    localparam logic [DW-1:0] INV_NUM = DW'(1) << (RESULT_FRAC_BITS + 30);

    // Magnitude of a working value, cut to the width of the shared units.
    function automatic logic [MW-1:0] mag_of(input pff_pkg::t_val v);
        pff_pkg::t_val a;
        a = (v < 0) ? -v : v;
        return a[MW-1:0];
    endfunction

    // Configuration registers.
    logic [31:0] r_lam, r_smooth;
    logic [5:0]  r_maxit;
    logic [23:0] r_tol;

    // Sequencer and datapath registers.
    logic [4:0]    r_state, n_state, r_ret, n_ret, r_lnret, n_lnret;
    logic [39:0]   r_re, n_re;
    logic [23:0]   r_eps, n_eps;
    logic          r_mneg, n_mneg;
    logic [MW-1:0] r_mmag, n_mmag;
    logic [31:0]   r_mc, n_mc;
    logic [63:0]   r_plo, n_plo;
    pff_pkg::t_val r_res, n_res, r_e, n_e, r_x, n_x, r_xold, n_xold;
    logic [MW-1:0] r_lv, n_lv;
    logic [5:0]    r_lp, n_lp;
    logic          r_lfb30, n_lfb30;
    logic [31:0]   r_lm, n_lm;
    logic [29:0]   r_lfrac, n_lfrac;
    logic [4:0]    r_lcnt, n_lcnt;
    logic [5:0]    r_iter, n_iter;
    logic          r_tneg, n_tneg;
    logic [MW-1:0] r_ia, n_ia;
    logic [31:0]   r_f, n_f;
    logic [1:0]    r_st, n_st;

    // Shared units.
    logic [31:0]       mul_a, mul_b;
    logic [63:0]       mul_p;
    pff_pkg::t_div_req div_req;
    pff_pkg::t_div_rsp div_rsp;

    // Combinational helpers.
    logic [87:0]   msum;
    logic [32:0]   sq;
    logic [7:0]    pe;
    pff_pkg::t_val lval, qv, zv, xn, dv;
    logic [5:0]    iter_inc;

    pff_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    pff_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lam    <= 32'd3000;
            r_smooth <= 32'd5000000;
            r_maxit  <= 6'd20;
            r_tol    <= 24'd168;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pff_pkg::CFG_LAMINAR: r_lam    <= i_cfg_data;
                pff_pkg::CFG_SMOOTH:  r_smooth <= i_cfg_data;
                pff_pkg::CFG_MAXIT:   r_maxit  <= i_cfg_data[5:0];
                pff_pkg::CFG_TOL:     r_tol    <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Operand selection of the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_DISP: begin
                mul_a = {8'd0, r_eps};
                mul_b = pff_pkg::EPS_DIV37;
            end
            S_MLO: begin
                mul_a = {8'd0, r_mmag[23:0]};
                mul_b = r_mc;
            end
            S_MHI: begin
                mul_a = {8'd0, r_mmag[47:24]};
                mul_b = r_mc;
            end
            S_LSQ: begin
                mul_a = r_lm;
                mul_b = r_lm;
            end
            default: ;
        endcase
    end

    // Helper arithmetic shared by several states.
    assign msum     = {mul_p, 24'd0} + {24'd0, r_plo};
    assign sq       = mul_p[63:31];
    assign iter_inc = r_iter + 6'd1;
    assign qv       = r_tneg ? -pff_pkg::t_val'(div_rsp.quot[VW-2:0])
                             : pff_pkg::t_val'(div_rsp.quot[VW-2:0]);
    assign zv       = r_e + qv;
    assign xn       = -r_res;
    assign dv       = (xn - r_xold < 0) ? r_xold - xn : xn - r_xold;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_lnret = r_lnret;
        n_re    = r_re;
        n_eps   = r_eps;
        n_mneg  = r_mneg;
        n_mmag  = r_mmag;
        n_mc    = r_mc;
        n_plo   = r_plo;
        n_res   = r_res;
        n_e     = r_e;
        n_x     = r_x;
        n_xold  = r_xold;
        n_lv    = r_lv;
        n_lp    = r_lp;
        n_lfb30 = r_lfb30;
        n_lm    = r_lm;
        n_lfrac = r_lfrac;
        n_lcnt  = r_lcnt;
        n_iter  = r_iter;
        n_tneg  = r_tneg;
        n_ia    = r_ia;
        n_f     = r_f;
        n_st    = r_st;
        div_req = '0;
        pe      = '0;
        lval    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_re    = i_in.reynolds;
                    n_eps   = i_in.rel_roughness;
                    n_st    = pff_pkg::ST_OK;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (r_re == '0) begin
                    n_f     = pff_pkg::SAT_VALUE;
                    n_st    = pff_pkg::ST_SAT;
                    n_state = S_OUT;
                end else if (r_re <= {r_lam, 8'd0}) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = LAM_NUM;
                    div_req.divisor  = {8'd0, r_re};
                    n_ret            = S_LAM;
                    n_state          = S_DIVW;
                end else if (r_eps == '0) begin
                    if (r_re > {r_smooth, 8'd0}) begin
                        n_f     = '0;
                        n_st    = pff_pkg::ST_RANGE;
                        n_state = S_OUT;
                    end else begin
                        n_lv    = {8'd0, r_re};
                        n_lp    = 6'd47;
                        n_lfb30 = 1'b0;
                        n_lnret = S_SM1;
                        n_state = S_LNORM;
                    end
                end else begin
                    // The multiplier forms eps times 11/37 for the next state.
                    n_state = S_E;
                end
            end
            S_DIVW: begin
                if (div_rsp.done) begin
                    n_state = r_ret;
                end
            end
            // Product of a 48-bit magnitude and a Q.30 constant, in two halves.
            S_MLO: n_state = S_MHI;
            S_MHI: begin
                n_plo   = mul_p;
                n_state = S_MSUM;
            end
            S_MSUM: begin
                n_res   = r_mneg ? -pff_pkg::t_val'(msum[79:30])
                                 : pff_pkg::t_val'(msum[79:30]);
                n_state = r_ret;
            end
            // Logarithm: find the leading one, one position a cycle.
            S_LNORM: begin
                if (r_lv[MW-1]) begin
                    n_lm    = r_lv[MW-1:MW-32];
                    n_lfrac = '0;
                    n_lcnt  = 5'd29;
                    n_state = S_LSQ;
                end else begin
                    n_lv = {r_lv[MW-2:0], 1'b0};
                    n_lp = r_lp - 6'd1;
                end
            end
            S_LSQ: n_state = S_LSQW;
            S_LSQW: begin
                if (sq[32]) begin
                    n_lm              = sq[32:1];
                    n_lfrac[r_lcnt]   = 1'b1;
                end else begin
                    n_lm = sq[31:0];
                end
                if (r_lcnt == '0) begin
                    pe      = {2'd0, r_lp} - (r_lfb30 ? 8'd30 : 8'd8);
                    lval    = {{(VW-38){pe[7]}}, pe, n_lfrac};
                    n_mneg  = lval[VW-1];
                    n_mmag  = mag_of(lval);
                    n_mc    = pff_pkg::Q30_LN2;
                    n_ret   = r_lnret;
                    n_state = S_MLO;
                end else begin
                    n_lcnt  = r_lcnt - 5'd1;
                    n_state = S_LSQ;
                end
            end
            S_LAM: begin
                if (|div_rsp.quot[63:32]) begin
                    n_f  = pff_pkg::SAT_VALUE;
                    n_st = pff_pkg::ST_SAT;
                end else begin
                    n_f = div_rsp.quot[31:0];
                end
                n_state = S_OUT;
            end
            S_SM1: begin
                n_mneg  = r_res[VW-1];
                n_mmag  = mag_of(r_res);
                n_mc    = pff_pkg::Q30_C079;
                n_ret   = S_SM2;
                n_state = S_MLO;
            end
            S_SM2: begin
                n_ia    = mag_of(r_res - pff_pkg::t_val'(pff_pkg::Q30_C164));
                n_state = S_INV0;
            end
            // eps*640/37 is 17*eps plus floor(11*eps/37).
            S_E: begin
                n_e     = pff_pkg::t_val'({r_eps, 4'd0}) + pff_pkg::t_val'(r_eps)
                        + pff_pkg::t_val'(mul_p[63:30]);
                n_x     = '0;
                n_iter  = '0;
                n_state = S_ITER;
            end
            // Colebrook fixed-point step.
            S_ITER: begin
                n_xold  = r_x;
                n_mneg  = r_x[VW-1];
                n_mmag  = mag_of(r_x);
                n_mc    = pff_pkg::Q30_C251;
                n_ret   = S_IT1;
                n_state = S_MLO;
            end
            S_IT1: begin
                n_tneg           = r_res[VW-1];
                div_req.start    = 1'b1;
                div_req.dividend = {8'd0, mag_of(r_res), 8'd0};
                div_req.divisor  = {8'd0, r_re};
                n_ret            = S_IT2;
                n_state          = S_DIVW;
            end
            S_IT2: begin
                if (zv <= 0) begin
                    n_f     = pff_pkg::SAT_VALUE;
                    n_st    = pff_pkg::ST_SAT;
                    n_state = S_OUT;
                end else begin
                    n_lv    = zv[MW-1:0];
                    n_lp    = 6'd47;
                    n_lfb30 = 1'b1;
                    n_lnret = S_IT3;
                    n_state = S_LNORM;
                end
            end
            S_IT3: begin
                n_mneg  = r_res[VW-1];
                n_mmag  = mag_of(r_res);
                n_mc    = pff_pkg::Q30_C086;
                n_ret   = S_IT4;
                n_state = S_MLO;
            end
            S_IT4: begin
                n_x    = xn;
                n_iter = iter_inc;
                n_ia   = mag_of(xn);
                if (dv <= pff_pkg::t_val'({r_tol, 6'd0})) begin
                    n_state = S_INV0;
                end else if (iter_inc >= r_maxit) begin
                    n_st    = pff_pkg::ST_NOCONV;
                    n_state = S_INV0;
                end else begin
                    n_state = S_ITER;
                end
            end
            // One over a squared: two divisions by a.
            S_INV0: begin
                if (r_ia == '0) begin
                    n_f     = pff_pkg::SAT_VALUE;
                    n_st    = (r_st == pff_pkg::ST_OK) ? pff_pkg::ST_SAT : r_st;
                    n_state = S_OUT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = INV_NUM;
                    div_req.divisor  = r_ia;
                    n_ret            = S_INV1;
                    n_state          = S_DIVW;
                end
            end
            S_INV1: begin
                if (|div_rsp.quot[63:33]) begin
                    n_f     = pff_pkg::SAT_VALUE;
                    n_st    = (r_st == pff_pkg::ST_OK) ? pff_pkg::ST_SAT : r_st;
                    n_state = S_OUT;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {1'b0, div_rsp.quot[32:0], 30'd0};
                    div_req.divisor  = r_ia;
                    n_ret            = S_INV2;
                    n_state          = S_DIVW;
                end
            end
            S_INV2: begin
                if (|div_rsp.quot[63:32]) begin
                    n_f  = pff_pkg::SAT_VALUE;
                    n_st = (r_st == pff_pkg::ST_OK) ? pff_pkg::ST_SAT : r_st;
                end else begin
                    n_f = div_rsp.quot[31:0];
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_lnret <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_lnret <= n_lnret;
            r_iter  <= n_iter;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_re    <= n_re;
        r_eps   <= n_eps;
        r_mneg  <= n_mneg;
        r_mmag  <= n_mmag;
        r_mc    <= n_mc;
        r_plo   <= n_plo;
        r_res   <= n_res;
        r_e     <= n_e;
        r_x     <= n_x;
        r_xold  <= n_xold;
        r_lv    <= n_lv;
        r_lp    <= n_lp;
        r_lfb30 <= n_lfb30;
        r_lm    <= n_lm;
        r_lfrac <= n_lfrac;
        r_lcnt  <= n_lcnt;
        r_tneg  <= n_tneg;
        r_ia    <= n_ia;
        r_f     <= n_f;
        r_st    <= n_st;
    end

    // Channel outputs.
    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = (r_state == S_OUT);
    assign o_out.friction_factor = r_f;
    assign o_out.status          = r_st;

    // No new transaction is taken while a result is still pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_out.valid && i_in.ready))
        else $error("input accepted while a result is pending");

    // The divider only completes while the sequencer waits for it.
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIVW))
        else $error("divider finished outside its wait state");

    // The rough loop never starts a step beyond the iteration limit, the first step apart.
    a_iter_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER) |-> (r_iter == '0 || r_iter < r_maxit))
        else $error("iteration count passed the limit");

    // An out of range result always carries a zero factor.
    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == pff_pkg::ST_RANGE) |-> (o_out.friction_factor == '0))
        else $error("out of range result with non-zero factor");

endmodule

FILE: test/pipe_friction_factor_core_tb.sv
// Self-checking testbench of the pipe friction factor core: directed table, then random items.
module pipe_friction_factor_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int NUM_PHASES     = 5;

    typedef struct {
        logic [31:0] factor;
        logic [1:0]  status;
    } t_friction;

    typedef struct {
        logic [39:0] reynolds;
        logic [23:0] roughness;
        bit          typed;
        logic [31:0] factor;
        logic [1:0]  status;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = pff_pkg::CFG_LAMINAR;
    logic [31:0] i_cfg_data = '0;

    pff_in_if  in_ch ();
    pff_out_if out_ch ();

    pipe_friction_factor_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Shadow copy of the configuration registers.
    logic [31:0] lam_limit = 32'd3000;
    logic [31:0] smooth_limit = 32'd5000000;
    logic [5:0]  iter_limit = 6'd20;
    logic [23:0] tol_q24 = 24'd168;

    t_friction expected_q[$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        recv_hold = 0;

    // (a * c) / 2^30 with the magnitude truncated.
    function automatic longint scale_q30(longint a, longint unsigned c);
        bit neg;
        longint unsigned mag, hi, lo, r;
        neg = a < 0;
        mag = neg ? longint'(0) - a : a;
        hi = mag >> 15;
        lo = mag & 64'h7FFF;
        r = (hi * c + ((lo * c) >> 15)) >> 15;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // Natural logarithm of v with fb fraction bits, result in Q.30.
    function automatic longint natural_log_q30(longint unsigned v, int fb);
        int p;
        longint unsigned m, frac;
        p = 63;
        frac = 0;
        while (p > 0 && v[p] == 1'b0) p--;
        if (p >= 31) m = v >> (p - 31);
        else m = v << (31 - p);
        for (int i = 29; i >= 0; i--) begin
            m = (m * m) >> 31;
            if (m >= (64'd1 << 32)) begin
                m = m >> 1;
                frac = frac | (64'd1 << i);
            end
        end
        return scale_q30(longint'(p - fb) * (64'sd1 <<< 30) + longint'(frac),
                         pff_pkg::Q30_LN2);
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    // Friction factor 1/a^2 in result format; sets sat on overflow or zero divisor.
    function automatic longint unsigned inverse_square(longint unsigned a, inout bit sat);
        longint unsigned h, f;
        if (a == 0) begin
            sat = 1'b1;
            return pff_pkg::SAT_VALUE;
        end
        h = (64'd1 << (pff_pkg::RESULT_FRAC_BITS + 30)) / a;
        if (h >= (64'd1 << 33)) begin
            sat = 1'b1;
            return pff_pkg::SAT_VALUE;
        end
        f = (h << 30) / a;
        if (f > 64'hFFFF_FFFF) begin
            sat = 1'b1;
            return pff_pkg::SAT_VALUE;
        end
        return f;
    endfunction

    // Darcy friction factor and status of one transaction under the current configuration.
    function automatic t_friction darcy_factor(logic [39:0] reynolds, logic [23:0] roughness);
        t_friction res;
        longint unsigned re, f, qm, iter;
        longint e, tol, x, x_prev, t, q, z, d, a;
        bit sat, bad, done;
        logic [1:0] st;
        re = reynolds;
        sat = 1'b0;
        bad = 1'b0;
        done = 1'b0;
        st = pff_pkg::ST_OK;
        f = 0;
        if (re == 0) begin
            f = pff_pkg::SAT_VALUE;
            st = pff_pkg::ST_SAT;
        end else if (re <= (longint'(lam_limit) << 8)) begin
            f = (64'd64 << (pff_pkg::RESULT_FRAC_BITS + 8)) / re;
            if (f > 64'hFFFF_FFFF) begin
                f = pff_pkg::SAT_VALUE;
                sat = 1'b1;
            end
        end else if (roughness == 0) begin
            if (re > (longint'(smooth_limit) << 8)) begin
                f = 0;
                st = pff_pkg::ST_RANGE;
            end else begin
                a = scale_q30(natural_log_q30(re, 8), pff_pkg::Q30_C079)
                    - longint'(pff_pkg::Q30_C164);
                f = inverse_square(magnitude(a), sat);
            end
        end else begin
            // Colebrook fixed-point iteration from x = 0.
            e = (longint'(roughness) * 640) / 37;
            tol = longint'(tol_q24) << 6;
            x = 0;
            iter = 0;
            while (!done) begin
                x_prev = x;
                t = scale_q30(x_prev, pff_pkg::Q30_C251);
                qm = (magnitude(t) << 8) / re;
                q = t < 0 ? -longint'(qm) : longint'(qm);
                z = e + q;
                if (z <= 0) begin
                    bad = 1'b1;
                    break;
                end
                x = -scale_q30(natural_log_q30(z, 30), pff_pkg::Q30_C086);
                iter++;
                d = magnitude(x - x_prev);
                if (d <= tol) done = 1'b1;
                else if (iter >= iter_limit) begin
                    st = pff_pkg::ST_NOCONV;
                    done = 1'b1;
                end
            end
            if (bad) begin
                f = pff_pkg::SAT_VALUE;
                st = pff_pkg::ST_SAT;
            end else begin
                f = inverse_square(magnitude(x), sat);
            end
        end
        if (sat && st == pff_pkg::ST_OK) st = pff_pkg::ST_SAT;
        res.factor = f[31:0];
        res.status = st;
        return res;
    endfunction

    // Register write at one clock edge; the shadow copy follows.
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            pff_pkg::CFG_LAMINAR: lam_limit = data;
            pff_pkg::CFG_SMOOTH:  smooth_limit = data;
            pff_pkg::CFG_MAXIT:   iter_limit = data[5:0];
            pff_pkg::CFG_TOL:     tol_q24 = data[23:0];
            default: ;
        endcase
    endtask

    // Offer one transaction and record its expectation once accepted.
    task automatic send_item(logic [39:0] reynolds, logic [23:0] roughness, bit typed,
                             t_friction typed_res);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        in_ch.valid = 1'b1;
        in_ch.reynolds = reynolds;
        in_ch.rel_roughness = roughness;
        forever begin
            @(posedge i_clk);
            if (in_ch.ready) break;
        end
        expected_q.push_back(typed ? typed_res : darcy_factor(reynolds, roughness));
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    function automatic logic [39:0] rand40();
        return {8'($urandom_range(255)), $urandom};
    endfunction

    // Reynolds numbers spread over the laminar, smooth and rough regions and the limits.
    function automatic logic [39:0] pick_reynolds();
        longint unsigned lim;
        case ($urandom_range(9))
            0: return ($urandom_range(3) == 0) ? 40'd0 : 40'($urandom_range(1, 255));
            1, 2: begin
                lim = (longint'(lam_limit) << 8) + 1;
                return 40'(longint'(rand40()) % lim);
            end
            3: begin
                lim = ($urandom_range(1)) ? longint'(lam_limit) : longint'(smooth_limit);
                return 40'((lim << 8) + $urandom_range(4) - 2);
            end
            4, 5, 6: return {8'($urandom_range(4000, 10000000) >> 24),
                             24'($urandom_range(4000, 10000000)), 8'($urandom)};
            7, 8: return rand40();
            default: return 40'($urandom_range(1, 4096));
        endcase
    endfunction

    function automatic logic [23:0] pick_roughness();
        case ($urandom_range(2))
            0: return 24'd0;
            1: return 24'($urandom);
            default: return 24'($urandom_range(1, 65535));
        endcase
    endfunction

    // Receiver: random stalls, plus a long hold-off counted here.
    always @(negedge i_clk) begin
        if (recv_hold > 0) begin
            out_ch.ready = 1'b0;
            recv_hold = recv_hold - 1;
        end else begin
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result check against the oldest expectation.
    always @(posedge i_clk) begin
        t_friction want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: factor %h status %0d",
                             out_ch.friction_factor, out_ch.status);
            end else begin
                want = expected_q.pop_front();
                if (out_ch.friction_factor !== want.factor || out_ch.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected factor %h status %0d, got %h status %0d",
                                 want.factor, want.status, out_ch.friction_factor,
                                 out_ch.status);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        int quiet;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
        else quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("FAIL pipe_friction_factor_core");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_directed_row dir_rows[$];
        t_friction     typed_res;
        logic [31:0]   cfg_set[NUM_PHASES][4];
        int            phase_items[NUM_PHASES];

        in_ch.valid = 1'b0;
        in_ch.reynolds = '0;
        in_ch.rel_roughness = '0;

        // Phase settings: laminar limit, smooth limit, iteration limit, tolerance.
        cfg_set[0] = '{32'd3000, 32'd5000000, 32'd20, 32'd168};
        cfg_set[1] = '{32'd0, 32'hFFFF_FFFF, 32'd63, 32'd1};
        cfg_set[2] = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'hFF_FFFF};
        cfg_set[3] = '{32'd1000, 32'd100000, 32'd0, 32'd168};
        cfg_set[4] = '{32'd10, 32'd5000000, 32'd5, 32'd16};
        phase_items = '{600, 200, 250, 225, 225};

        // Directed rows under the reset configuration.
        dir_rows = '{
            '{40'd0, 24'd0, 1'b1, pff_pkg::SAT_VALUE, pff_pkg::ST_SAT},
            '{40'd0, 24'hFF_FFFF, 1'b1, pff_pkg::SAT_VALUE, pff_pkg::ST_SAT},
            '{40'd1, 24'd0, 1'b1, pff_pkg::SAT_VALUE, pff_pkg::ST_SAT},
            '{40'd256, 24'd12345, 1'b1, 32'h4000_0000, pff_pkg::ST_OK},
            '{40'd768000, 24'd0, 1'b0, 32'd0, pff_pkg::ST_OK},
            '{40'd768001, 24'd0, 1'b0, 32'd0, pff_pkg::ST_OK},
            '{40'd768001, 24'hFF_FFFF, 1'b0, 32'd0, pff_pkg::ST_OK},
            '{40'd1280000000, 24'd0, 1'b0, 32'd0, pff_pkg::ST_OK},
            '{40'd1280000001, 24'd0, 1'b1, 32'd0, pff_pkg::ST_RANGE},
            '{40'hFF_FFFF_FFFF, 24'd0, 1'b1, 32'd0, pff_pkg::ST_RANGE},
            '{40'hFF_FFFF_FFFF, 24'hFF_FFFF, 1'b0, 32'd0, pff_pkg::ST_OK},
            '{40'hFF_FFFF_FFFF, 24'd1, 1'b0, 32'd0, pff_pkg::ST_OK},
            '{40'd25600000, 24'd1678, 1'b0, 32'd0, pff_pkg::ST_OK},
            '{40'd25600000, 24'd1, 1'b0, 32'd0, pff_pkg::ST_OK},
            '{40'd1024000, 24'd838861, 1'b0, 32'd0, pff_pkg::ST_OK},
            '{40'd2560000, 24'h55_5555, 1'b0, 32'd0, pff_pkg::ST_OK},
            '{40'h55_5555_5555, 24'hAA_AAAA, 1'b0, 32'd0, pff_pkg::ST_OK},
            '{40'hAA_AAAA_AAAA, 24'h55_5555, 1'b0, 32'd0, pff_pkg::ST_OK}
        };

        // Hold reset, then release it.
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r]) begin
            typed_res.factor = dir_rows[r].factor;
            typed_res.status = dir_rows[r].status;
            send_item(dir_rows[r].reynolds, dir_rows[r].roughness, dir_rows[r].typed,
                      typed_res);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // The block is idle once every expected result has come.
            if (ph > 0) begin
                send_idle_pct = 0;
                wait (expected_q.size() == 0);
                for (int k = 0; k < 4; k++) write_reg(2'(k), cfg_set[ph][k]);
            end
            // Long receiver hold-off while items keep coming.
            if (ph == 0) begin
                recv_stall_pct = 0;
                recv_hold = 3000;
                for (int k = 0; k < 6; k++)
                    send_item(pick_reynolds(), pick_roughness(), 1'b0, typed_res);
            end
            for (int i = 0; i < phase_items[ph]; i++) begin
                case ((i / 50) % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                    default: begin send_idle_pct = 27; recv_stall_pct = 27; end
                endcase
                send_item(pick_reynolds(), pick_roughness(), 1'b0, typed_res);
            end
        end

        // Drain, then a short settling time.
        wait (expected_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0) begin
            $display("PASS pipe_friction_factor_core");
        end else begin
            $display("FAIL pipe_friction_factor_core");
        end
        $finish;
    end

endmodule
